// ===== rtl/rbht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbht_pkg - shared types and constants for the ray/box hit test
// Default widths and the word carried from the front end to the back end.
// ----------------------------------------------------------------------------
package rbht_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH     = 8;

  // per-axis face classification from the front end
  typedef struct packed {
    logic in_box;
    logic [2:0] face_ok;
  } rbht_class_t;

endpackage

// ===== rtl/rbht_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbht_front - input stage
// Registers the item and works out inside-box, which face is approached on
// each axis, the face gap and the per-axis offsets used by the back end.
// ----------------------------------------------------------------------------
module rbht_front #(
  parameter int CW = 32,
  parameter int HW = 18
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] o [3],
  input  logic signed [HW-1:0] h [3],
  input  logic signed [CW-1:0] lo [3],
  input  logic signed [CW-1:0] hi [3],
  output logic                 out_valid,
  output rbht_pkg::rbht_class_t cls,
  output logic signed [HW:0]   e [3],
  output logic signed [CW:0]   gap [3],
  output logic signed [HW:0]   hs [3],
  output logic signed [CW:0]   dlo [3],
  output logic signed [CW:0]   dhi [3]
);
  import rbht_pkg::*;

  rbht_class_t cls_next;
  logic signed [HW:0] e_next [3];
  logic signed [CW:0] gap_next [3];

  always_comb begin
    cls_next.in_box = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (o[i] < lo[i] || o[i] > hi[i]) cls_next.in_box = 1'b0;
      cls_next.face_ok[i] = 1'b0;
      e_next[i] = '0;
      gap_next[i] = '0;
      if (h[i] > 0 && o[i] < lo[i]) begin
        cls_next.face_ok[i] = 1'b1;
        e_next[i] = (HW+1)'(h[i]);
        gap_next[i] = (CW+1)'(lo[i]) - (CW+1)'(o[i]);
      end else if (h[i] < 0 && o[i] > hi[i]) begin
        cls_next.face_ok[i] = 1'b1;
        e_next[i] = -(HW+1)'(h[i]);
        gap_next[i] = (CW+1)'(o[i]) - (CW+1)'(hi[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    cls <= cls_next;
    for (int i = 0; i < 3; i++) begin
      e[i]   <= e_next[i];
      gap[i] <= gap_next[i];
      hs[i]  <= (HW+1)'(h[i]);
      dlo[i] <= (CW+1)'(o[i]) - (CW+1)'(lo[i]);
      dhi[i] <= (CW+1)'(hi[i]) - (CW+1)'(o[i]);
    end
  end

endmodule

// ===== rtl/rbht_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbht_back - bound test stage
// Two registered stages: the products, then the sums, signs and final hit.
// Carries a valid bit only; no stall, the output queue absorbs results.
// ----------------------------------------------------------------------------
module rbht_back #(
  parameter int CW = 32,
  parameter int HW = 18
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  rbht_pkg::rbht_class_t cls,
  input  logic signed [HW:0]   e [3],
  input  logic signed [CW:0]   gap [3],
  input  logic signed [HW:0]   hs [3],
  input  logic signed [CW:0]   dlo [3],
  input  logic signed [CW:0]   dhi [3],
  output logic                 out_valid,
  output logic                 hit
);
  import rbht_pkg::*;

  localparam int PW = CW + HW + 2;

  // products per face axis a, other-axis slot k
  logic signed [PW-1:0] pa [3][2];
  logic signed [PW-1:0] pb [3][2];
  logic signed [PW-1:0] pc [3][2];
  logic signed [PW-1:0] pd [3][2];
  rbht_class_t cls_q;
  logic v1;
  logic [2:0] ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      out_valid <= v1;
    end
    cls_q <= cls;
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 2; k++) begin
        pa[a][k] <= PW'(dlo[(a+k+1)%3]) * PW'(e[a]);
        pb[a][k] <= PW'(hs[(a+k+1)%3]) * PW'(gap[a]);
        pc[a][k] <= PW'(dhi[(a+k+1)%3]) * PW'(e[a]);
        pd[a][k] <= PW'(hs[(a+k+1)%3]) * PW'(gap[a]);
      end
    end
    hit <= cls_q.in_box || (|ok);
  end

  // below: dlo*e + h*gap >= 0; above: dhi*e - h*gap >= 0
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ok[a] = cls_q.face_ok[a];
      for (int k = 0; k < 2; k++) begin
        if ((PW+1)'(pa[a][k]) + (PW+1)'(pb[a][k]) < 0) ok[a] = 1'b0;
        if ((PW+1)'(pc[a][k]) - (PW+1)'(pd[a][k]) < 0) ok[a] = 1'b0;
      end
    end
  end

endmodule

// ===== rtl/rbht_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbht_queue - result queue
// Small register queue of hit bits; also tracks words still in flight so
// full is raised early enough that no result is ever dropped.
// ----------------------------------------------------------------------------
module rbht_queue #(
  parameter int DEPTH = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic wr,
  input  logic din,
  input  logic pop,
  output logic empty,
  output logic full,
  output logic dout
);
  localparam int AW = $clog2(DEPTH);

  logic [DEPTH-1:0] mem;
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt, credit, credit_next;
  logic rd;

  assign empty = (cnt == '0);
  assign rd    = pop && !empty;
  assign dout  = mem[rp];
  assign full  = (credit == (AW+1)'(DEPTH));
  assign credit_next = credit + (AW+1)'(accept) - (AW+1)'(rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
      credit <= '0;
    end else begin
      credit <= credit_next;
      if (wr) wp <= AW'((wp + 1'b1) % DEPTH);
      if (rd) rp <= AW'((rp + 1'b1) % DEPTH);
      cnt <= cnt + (AW+1)'(wr) - (AW+1)'(rd);
    end
    if (wr) mem[wp] <= din;
  end

endmodule

// ===== rtl/ray_box_hit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_hit_test - ray versus axis-aligned box hit test
// Accepts one ray/box word per cycle while full is low and returns one hit bit per word.
// ----------------------------------------------------------------------------
// One word is accepted every cycle while full is low; each result passes
// through the front register, product register and sum/sign register, then
// the write into the result queue, before it is on the result ports and
// can be popped.
// The 8-entry result queue counts words in flight as well as waiting ones:
// full rises once eight words are pushed and not yet popped. With pop held
// high at most four words are outstanding, so words flow with no stall.
module ray_box_hit_test #(
  parameter int COORD_WIDTH = rbht_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbht_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  input  logic signed [COORD_WIDTH-1:0] origin_z,
  input  logic signed [FRAC_BITS+1:0]   heading_x,
  input  logic signed [FRAC_BITS+1:0]   heading_y,
  input  logic signed [FRAC_BITS+1:0]   heading_z,
  input  logic signed [COORD_WIDTH-1:0] box_low_x,
  input  logic signed [COORD_WIDTH-1:0] box_low_y,
  input  logic signed [COORD_WIDTH-1:0] box_low_z,
  input  logic signed [COORD_WIDTH-1:0] box_high_x,
  input  logic signed [COORD_WIDTH-1:0] box_high_y,
  input  logic signed [COORD_WIDTH-1:0] box_high_z,
  output logic empty,
  input  logic pop,
  output logic hit
);
  import rbht_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int HW = FRAC_BITS + 2;

  logic signed [CW-1:0] o [3], lo [3], hi [3];
  logic signed [HW-1:0] h [3];
  logic accept, fv, bv, bhit;
  rbht_class_t cls;
  logic signed [HW:0] e [3], hs [3];
  logic signed [CW:0] gap [3], dlo [3], dhi [3];

  assign o  = '{origin_x, origin_y, origin_z};
  assign h  = '{heading_x, heading_y, heading_z};
  assign lo = '{box_low_x, box_low_y, box_low_z};
  assign hi = '{box_high_x, box_high_y, box_high_z};
  assign accept = push && !full;

  rbht_front #(.CW(CW), .HW(HW)) u_front (
    .clk, .rst, .in_valid(accept), .o, .h, .lo, .hi,
    .out_valid(fv), .cls, .e, .gap, .hs, .dlo, .dhi
  );

  rbht_back #(.CW(CW), .HW(HW)) u_back (
    .clk, .rst, .in_valid(fv), .cls, .e, .gap, .hs, .dlo, .dhi,
    .out_valid(bv), .hit(bhit)
  );

  rbht_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .accept, .wr(bv), .din(bhit), .pop,
    .empty, .full, .dout(hit)
  );

endmodule

// ===== rtl/rbht_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbht_checker - port-level checks
// Watches the queue handshakes of the hit test from its ports.
// ----------------------------------------------------------------------------
module rbht_checker (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic hit
);
  // a waiting result word is always a real value
  a_known: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !$isunknown(hit))
    else $error("waiting result unknown");

  // result word holds while not popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(hit)))
    else $error("waiting result changed");

  // full is never high straight after reset
  a_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !$past(rst))
    else $error("full straight after reset");

  a_rst: assert property (@(posedge clk) $past(rst) |-> (empty && !full))
    else $error("queue not clear after reset");
endmodule

bind ray_box_hit_test rbht_checker u_rbht_checker (
  .clk, .rst, .push, .full, .empty, .pop, .hit
);
